@@ rtl/adjacency_matrix_dfs_order_core_macros.svh @@
// Assertion macros for the depth-first walk core and its checker.
// The user scope must provide clk and rst.
`ifndef ADJACENCY_MATRIX_DFS_ORDER_CORE_MACROS_SVH
`define ADJACENCY_MATRIX_DFS_ORDER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AMDFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("amdfs: assertion failed");

// Antecedent at one edge implies the consequent at the next edge.
`define AMDFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amdfs: next-cycle assertion failed");

`endif

@@ rtl/amdfs_pkg.sv @@
`timescale 1ns / 1ps

package amdfs_pkg;

  localparam int NODES_DEF = 64;
  localparam int NODE_W    = 6;
  localparam int CNT_W     = 7;
  localparam int REQ_W     = 2;
  localparam int WEIGHT_W  = 32;
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_EDGE  = 2'd0,
    REQ_WALK  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_WALK_RD,
    ST_WALK_EVAL,
    ST_POP_RD,
    ST_POP_LD,
    ST_FLUSH
  } state_t;

  // Control for the adjacency row store.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } adj_ctl_t;

endpackage

@@ rtl/amdfs_req_if.sv @@
`timescale 1ns / 1ps

interface amdfs_req_if;
  logic                                valid;
  logic                                ready;
  logic [amdfs_pkg::REQ_W-1:0]         req_type;
  logic [amdfs_pkg::NODE_W-1:0]        src_node;
  logic [amdfs_pkg::NODE_W-1:0]        dst_node;
  logic signed [amdfs_pkg::WEIGHT_W-1:0] weight;
  logic [amdfs_pkg::NODE_W-1:0]        start_node;

  modport source (
    output valid, req_type, src_node, dst_node, weight, start_node,
    input  ready
  );
  modport sink (
    input  valid, req_type, src_node, dst_node, weight, start_node,
    output ready
  );
endinterface

@@ rtl/amdfs_res_if.sv @@
`timescale 1ns / 1ps

interface amdfs_res_if;
  logic                         valid;
  logic                         ready;
  logic [amdfs_pkg::NODE_W-1:0] visited_node;
  logic                         last_in_run;
  logic                         bad_request;

  modport source (
    output valid, visited_node, last_in_run, bad_request,
    input  ready
  );
  modport sink (
    input  valid, visited_node, last_in_run, bad_request,
    output ready
  );
endinterface

@@ rtl/amdfs_adj_store.sv @@
`timescale 1ns / 1ps

// Adjacency rows in a single-port memory with a registered read.
// A valid bit per row makes reset and clear take effect at once;
// a row that was never written since reads as all zero.
module amdfs_adj_store #(
  parameter int NODES = amdfs_pkg::NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  amdfs_pkg::adj_ctl_t      ctl,
  input  logic [$clog2(NODES)-1:0] addr,
  input  logic [NODES-1:0]         wdata,
  output logic [NODES-1:0]         rdata
);

  logic [NODES-1:0] mem [NODES];
  logic [NODES-1:0] row_vld;
  logic [NODES-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl.clr) begin
        row_vld <= '0;
      end else if (ctl.wr) begin
        row_vld[addr] <= 1'b1;
      end
      if (ctl.rd) begin
        rd_vld_q <= row_vld[addr];
      end
    end
  end

  assign rdata = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/adjacency_matrix_dfs_order_core.sv @@
`timescale 1ns / 1ps

// Depth-first walk over a directed adjacency bit matrix of up to NODES
// vertices. Requests on req: add/remove edge (a read-modify-write of one
// row), clear and walk. A walk emits the vertices reachable from
// start_node in preorder, lowest neighbor first, and flags the final one
// with last_in_run; a start at or beyond node_count gives a single result
// with bad_request set. One request is in work at a time and req is not
// ready meanwhile. Each step of a walk reads one row from the single-port
// row memory and runs a find-first-set over it; a backtrack also reads
// the stack memory. A held result on res stalls the walk only when the
// next vertex is found or when the final result is due.
// node_count is written through cfg_we/cfg_wdata; the user must do so only
// while no request is open, as the block does not enforce it.
module adjacency_matrix_dfs_order_core #(
  parameter int NODES = amdfs_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [amdfs_pkg::CNT_W-1:0] cfg_wdata,
  amdfs_req_if.sink                   req,
  amdfs_res_if.source                 res
);

  localparam int NW = $clog2(NODES);
  localparam int DW = $clog2(NODES + 1);

  amdfs_pkg::state_t   state, state_next;
  amdfs_pkg::adj_ctl_t adj_ctl;

  logic [amdfs_pkg::CNT_W-1:0] node_count;
  logic [amdfs_pkg::CNT_W-1:0] eff_cnt;
  logic [NODES-1:0]            cnt_mask;
  logic [NODES-1:0]            visited;
  logic [DW-1:0]               depth;
  logic [DW-1:0]               depth_dec;
  logic [NW-1:0]               top;
  logic [NW-1:0]               pend;
  logic                        pend_bad;
  logic [NW-1:0]               e_src;
  logic [NW-1:0]               e_dst;
  logic                        e_set;

  logic [NW-1:0]    stack [NODES];
  logic [NW-1:0]    stack_q;
  logic             stk_we;
  logic [NW-1:0]    stk_waddr;
  logic [NW-1:0]    stk_wdata;
  logic             stk_re;

  logic [NW-1:0]    adj_addr;
  logic [NODES-1:0] adj_wdata;
  logic [NODES-1:0] adj_rdata;
  logic [NODES-1:0] cand;
  logic [NW-1:0]    nx;
  logic             has_cand;

  logic                         out_valid;
  logic [amdfs_pkg::NODE_W-1:0] out_node;
  logic                         out_last;
  logic                         out_bad;

  logic acc;
  logic start_ok;
  logic slot_free;
  logic push;
  logic pop;
  logic flush;

  amdfs_adj_store #(
    .NODES(NODES)
  ) u_adj_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (adj_ctl),
    .addr  (adj_addr),
    .wdata (adj_wdata),
    .rdata (adj_rdata)
  );

  assign eff_cnt = (node_count > amdfs_pkg::CNT_W'(NODES)) ?
                   amdfs_pkg::CNT_W'(NODES) : node_count;

  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      cnt_mask[j] = (amdfs_pkg::CNT_W'(j) < eff_cnt);
    end
  end

  // Unvisited neighbors of the current top, lowest index wins.
  assign cand     = adj_rdata & ~visited & cnt_mask;
  assign has_cand = |cand;

  always_comb begin
    nx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        nx = NW'(i);
      end
    end
  end

  assign depth_dec = depth - DW'(1);
  assign acc       = req.valid && req.ready;
  assign start_ok  = ({1'b0, req.start_node} < eff_cnt);
  assign slot_free = !out_valid || res.ready;
  assign req.ready = (state == amdfs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amdfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    adj_ctl    = '0;
    adj_addr   = top;
    adj_wdata  = adj_rdata;
    stk_we     = 1'b0;
    stk_waddr  = depth[NW-1:0];
    stk_wdata  = nx;
    stk_re     = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    flush      = 1'b0;
    case (state)
      amdfs_pkg::ST_IDLE: begin
        if (acc) begin
          case (amdfs_pkg::req_kind_t'(req.req_type))
            amdfs_pkg::REQ_EDGE: begin
              if ({1'b0, req.src_node} < eff_cnt && {1'b0, req.dst_node} < eff_cnt) begin
                state_next = amdfs_pkg::ST_EDGE_RD;
              end
            end
            amdfs_pkg::REQ_WALK: begin
              if (start_ok) begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = req.start_node[NW-1:0];
                state_next = amdfs_pkg::ST_WALK_RD;
              end else begin
                state_next = amdfs_pkg::ST_FLUSH;
              end
            end
            amdfs_pkg::REQ_CLEAR: begin
              adj_ctl.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      amdfs_pkg::ST_EDGE_RD: begin
        adj_ctl.rd = 1'b1;
        adj_addr   = e_src;
        state_next = amdfs_pkg::ST_EDGE_WR;
      end
      amdfs_pkg::ST_EDGE_WR: begin
        adj_ctl.wr = 1'b1;
        adj_addr   = e_src;
        adj_wdata  = e_set ? (adj_rdata | (NODES'(1) << e_dst)) :
                             (adj_rdata & ~(NODES'(1) << e_dst));
        state_next = amdfs_pkg::ST_IDLE;
      end
      amdfs_pkg::ST_WALK_RD: begin
        adj_ctl.rd = 1'b1;
        state_next = amdfs_pkg::ST_WALK_EVAL;
      end
      amdfs_pkg::ST_WALK_EVAL: begin
        if (has_cand) begin
          // Hold here until the output register can take the pending vertex.
          if (slot_free) begin
            push       = 1'b1;
            stk_we     = 1'b1;
            state_next = amdfs_pkg::ST_WALK_RD;
          end
        end else begin
          pop = 1'b1;
          if (depth == DW'(1)) begin
            state_next = amdfs_pkg::ST_FLUSH;
          end else begin
            state_next = amdfs_pkg::ST_POP_RD;
          end
        end
      end
      amdfs_pkg::ST_POP_RD: begin
        stk_re     = 1'b1;
        state_next = amdfs_pkg::ST_POP_LD;
      end
      amdfs_pkg::ST_POP_LD: begin
        adj_ctl.rd = 1'b1;
        adj_addr   = stack_q;
        state_next = amdfs_pkg::ST_WALK_EVAL;
      end
      amdfs_pkg::ST_FLUSH: begin
        if (slot_free) begin
          flush      = 1'b1;
          state_next = amdfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = amdfs_pkg::ST_IDLE;
      end
    endcase
  end

  // Walk stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stack_q <= stack[depth_dec[NW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= amdfs_pkg::CNT_RESET;
      visited    <= '0;
      depth      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      if (acc && req.req_type == amdfs_pkg::REQ_WALK) begin
        visited <= start_ok ? (NODES'(1) << req.start_node[NW-1:0]) : '0;
        depth   <= start_ok ? DW'(1) : '0;
      end
      if (push) begin
        visited[nx] <= 1'b1;
        depth       <= depth + DW'(1);
      end
      if (pop) begin
        depth <= depth_dec;
      end
      if (push || flush) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The newest vertex waits in pend until the walk shows whether it is last.
  always_ff @(posedge clk) begin
    if (acc) begin
      e_src <= req.src_node[NW-1:0];
      e_dst <= req.dst_node[NW-1:0];
      e_set <= (req.weight != '0);
      if (req.req_type == amdfs_pkg::REQ_WALK) begin
        top      <= req.start_node[NW-1:0];
        pend     <= start_ok ? req.start_node[NW-1:0] : '0;
        pend_bad <= !start_ok;
      end
    end
    if (push) begin
      out_node <= amdfs_pkg::NODE_W'(pend);
      out_last <= 1'b0;
      out_bad  <= 1'b0;
      pend     <= nx;
      top      <= nx;
    end
    if (state == amdfs_pkg::ST_POP_LD) begin
      top <= stack_q;
    end
    if (flush) begin
      out_node <= amdfs_pkg::NODE_W'(pend);
      out_last <= 1'b1;
      out_bad  <= pend_bad;
    end
  end

  assign res.valid        = out_valid;
  assign res.visited_node = out_node;
  assign res.last_in_run  = out_last;
  assign res.bad_request  = out_bad;

endmodule

@@ rtl/amdfs_checker.sv @@
`timescale 1ns / 1ps
`include "adjacency_matrix_dfs_order_core_macros.svh"

module amdfs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [amdfs_pkg::REQ_W-1:0]  req_type,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [amdfs_pkg::NODE_W-1:0] res_node,
  input logic                         res_last,
  input logic                         res_bad
);

  logic [amdfs_pkg::NODE_W+1:0] res_word;

  assign res_word = {res_node, res_last, res_bad};

  // A stalled result keeps its payload.
  `AMDFS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word))

  // A walk transfer closes the request side for at least the next cycle.
  `AMDFS_ASSERT_NEXT(a_walk_busy, req_valid && req_ready && req_type == amdfs_pkg::REQ_WALK, !req_ready)

  // While a walk still owes its last vertex, no new request is taken.
  `AMDFS_ASSERT(a_mid_busy, res_valid && res_ready && !res_last |-> !req_ready)

endmodule

bind adjacency_matrix_dfs_order_core amdfs_checker u_amdfs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_node  (res.visited_node),
  .res_last  (res.last_in_run),
  .res_bad   (res.bad_request)
);

@@ tb/sv/dfs_order_checker.sv @@
`timescale 1ns / 1ps

module dfs_order_checker
  import amdfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  amdfs_req_if             req,
  amdfs_res_if             res,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    logic              bad;
  } visit_t;

  logic [63:0]      adj_rows [64];
  logic [63:0]      seen;
  logic [CNT_W-1:0] count_reg;
  visit_t           expected_visits [$];
  int               mismatches = 0;

  assign fail_count = mismatches;

  // Preorder walk with an explicit stack; neighbors are tried lowest index first.
  function automatic void predict_preorder(input logic [NODE_W-1:0] start,
                                           input logic [CNT_W-1:0] cnt);
    logic [NODE_W-1:0] stack [64];
    logic [63:0]       mask;
    logic [63:0]       cand;
    int                depth;
    int                n;
    int                nx;
    visit_t            tail;
    seen = '0;
    if (start >= cnt) begin
      expected_visits.push_back(visit_t'{node: '0, last: 1'b1, bad: 1'b1});
      return;
    end
    mask = (cnt >= 64) ? '1 : ((64'd1 << cnt) - 64'd1);
    seen[start] = 1'b1;
    stack[0] = start;
    depth = 1;
    n = 1;
    expected_visits.push_back(visit_t'{node: start, last: 1'b0, bad: 1'b0});
    while (depth > 0) begin
      cand = adj_rows[stack[depth-1]] & ~seen & mask;
      if (cand != '0 && depth < NODES_DEF && n < 64) begin
        nx = 0;
        while (!cand[nx]) nx++;
        seen[nx] = 1'b1;
        stack[depth] = nx[NODE_W-1:0];
        depth++;
        n++;
        expected_visits.push_back(visit_t'{node: nx[NODE_W-1:0], last: 1'b0, bad: 1'b0});
      end else begin
        depth--;
      end
    end
    // flag the final vertex of the walk
    tail = expected_visits.pop_back();
    tail.last = 1'b1;
    expected_visits.push_back(tail);
  endfunction

  always @(posedge clk) begin : watch
    logic [CNT_W-1:0] cnt;
    visit_t           got;
    visit_t           want;
    if (rst) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      seen = '0;
      count_reg = CNT_RESET;
      expected_visits.delete();
    end else begin
      if (cfg_we) count_reg = cfg_wdata;
      cnt = (count_reg > 7'd64) ? 7'd64 : count_reg;

      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_EDGE: begin
            if (req.src_node < cnt && req.dst_node < cnt)
              adj_rows[req.src_node][req.dst_node] = (req.weight != 0);
          end
          REQ_CLEAR: foreach (adj_rows[i]) adj_rows[i] = '0;
          REQ_WALK:  predict_preorder(req.start_node, cnt);
          default: ;
        endcase
      end

      if (res.valid && res.ready) begin
        got = visit_t'{node: res.visited_node, last: res.last_in_run,
                       bad: res.bad_request};
        if (expected_visits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("dfs_order_checker: unexpected result node %0d last %0b bad %0b",
                     got.node, got.last, got.bad);
        end else begin
          want = expected_visits.pop_front();
          if (got.node !== want.node || got.last !== want.last || got.bad !== want.bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display("dfs_order_checker: mismatch expected node %0d last %0b bad %0b, got node %0d last %0b bad %0b",
                       want.node, want.last, want.bad, got.node, got.last, got.bad);
          end
        end
      end
    end
    pending <= expected_visits.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import amdfs_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES     = 400;
  localparam int LONG_HOLD        = 600;
  localparam int CYCLE_LIMIT      = 2_000_000;
  localparam int RANDOM_PER_PHASE = 10;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             calm;
  logic             hold_ask;
  bit               hold_done;
  logic [CNT_W-1:0] cur_count;
  int               fail_count;
  int               pending;
  int               cycles = 0;
  int               phase_counts [10] = '{8, 64, 127, 3, 0, 100, 16, 2, 1, 64};

  amdfs_req_if req_ch ();
  amdfs_res_if res_ch ();

  adjacency_matrix_dfs_order_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  dfs_order_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Offer one request after a random gap, or none while calm, and hold it until the transfer.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [NODE_W-1:0] s,
                          input logic [NODE_W-1:0] d, input logic signed [31:0] w,
                          input logic [NODE_W-1:0] st);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.src_node   <= s;
    req_ch.dst_node   <= d;
    req_ch.weight     <= w;
    req_ch.start_node <= st;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
  endtask

  // Drop valid, wait for every expected result, then let an open edge write finish.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_count = v;
  endtask

  function automatic logic [NODE_W-1:0] pick_node(input int eff);
    if (eff > 0 && $urandom_range(0, 9) != 0)
      return NODE_W'($urandom_range(0, eff - 1));
    return NODE_W'($urandom_range(0, 63));
  endfunction

  task automatic random_request(output bit useful);
    logic [REQ_W-1:0]  kind;
    logic [NODE_W-1:0] s;
    logic [NODE_W-1:0] d;
    logic [NODE_W-1:0] st;
    logic signed [31:0] w;
    int r;
    int eff;
    eff = (cur_count > 64) ? 64 : cur_count;
    r = $urandom_range(0, 99);
    kind = (r < 55) ? REQ_EDGE : (r < 88) ? REQ_WALK : (r < 92) ? REQ_CLEAR : REQ_UNUSED;
    s  = pick_node(eff);
    d  = pick_node(eff);
    st = pick_node(eff);
    w  = ($urandom_range(0, 3) == 0) ? 32'sd0 : $urandom;
    send_req(kind, s, d, w, st);
    useful = (kind == REQ_WALK) || (kind == REQ_CLEAR) ||
             (kind == REQ_EDGE && s < eff && d < eff);
  endtask

  initial begin : result_sink
    int gap;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 7);
      if (hold_ask && !hold_done) begin
        gap = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  initial begin : stimulus
    int counted;
    bit useful;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    calm      <= 1'b0;
    hold_ask  <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_EDGE;
    req_ch.src_node   <= '0;
    req_ch.dst_node   <= '0;
    req_ch.weight     <= '0;
    req_ch.start_node <= '0;
    cur_count = CNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // walk on the empty graph
    send_req(REQ_WALK, 0, 0, 0, 0);
    // extreme weights and endpoints, then removal of one edge
    send_req(REQ_EDGE, 0, 63, 32'sd1, 0);
    send_req(REQ_EDGE, 63, 0, 32'sh8000_0000, 0);
    send_req(REQ_EDGE, 0, 5, 32'sh7fff_ffff, 0);
    send_req(REQ_WALK, 0, 0, 0, 0);
    send_req(REQ_EDGE, 0, 5, 32'sd0, 0);
    send_req(REQ_WALK, 63, 63, 32'sh7fff_ffff, 0);
    // self loop
    send_req(REQ_EDGE, 5, 5, -32'sd1, 0);
    send_req(REQ_WALK, 0, 0, 0, 5);
    send_req(REQ_UNUSED, 63, 63, 32'shffff_ffff, 63);
    send_req(REQ_EDGE, 10, 40, 32'sd1, 0);
    // stale edge kept but not followed, endpoints beyond the count
    write_count(16);
    send_req(REQ_WALK, 0, 0, 0, 10);
    send_req(REQ_EDGE, 2, 20, 32'sd1, 0);
    send_req(REQ_WALK, 0, 0, 0, 16);
    send_req(REQ_WALK, 0, 0, 0, 15);
    // count above the node limit saturates
    write_count(127);
    send_req(REQ_WALK, 0, 0, 0, 10);
    send_req(REQ_WALK, 0, 0, 0, 63);
    send_req(REQ_CLEAR, 0, 0, 0, 0);
    send_req(REQ_WALK, 0, 0, 0, 63);
    // zero count: every walk is an error, every edge ignored
    write_count(0);
    send_req(REQ_WALK, 0, 0, 0, 0);
    send_req(REQ_EDGE, 0, 0, 32'sd1, 0);
    write_count(1);
    send_req(REQ_EDGE, 0, 0, 32'sd1, 0);
    send_req(REQ_WALK, 0, 0, 0, 0);
    send_req(REQ_WALK, 0, 0, 0, 1);

    for (int p = 0; p < 10; p++) begin
      write_count(CNT_W'(phase_counts[p]));
      calm <= (p == 6);
      if (p == 1) begin
        // chain through all vertices for the longest walk
        send_req(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom), $urandom,
                 NODE_W'($urandom));
        for (int i = 0; i < 63; i++)
          send_req(REQ_EDGE, NODE_W'(i), NODE_W'(i + 1), $urandom | 32'd1,
                   NODE_W'($urandom));
        send_req(REQ_WALK, NODE_W'($urandom), NODE_W'($urandom), $urandom, 0);
        send_req(REQ_WALK, NODE_W'($urandom), NODE_W'($urandom), $urandom, 30);
      end
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        if (p == 0 && counted == 5) hold_ask <= 1'b1;
        random_request(useful);
        if (useful) counted++;
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
